@@ sv/klc_pkg.sv @@
// shared types and constants of the keypad code lock controller
package klc_pkg;

  // operating modes of the lock
  typedef enum logic [2:0] {
    MODE_ENTRY   = 3'd0,
    MODE_OPEN    = 3'd1,
    MODE_LOCKOUT = 3'd2,
    MODE_OLD     = 3'd3,
    MODE_NEW     = 3'd4
  } mode_e;

  // event reported with each result
  typedef enum logic [3:0] {
    EV_NONE         = 4'd0,
    EV_DIGIT        = 4'd1,
    EV_ERASED       = 4'd2,
    EV_OPENED       = 4'd3,
    EV_WRONG        = 4'd4,
    EV_LOCKED       = 4'd5,
    EV_LOCKOUT      = 4'd6,
    EV_LOCKOUT_OVER = 4'd7,
    EV_RESET_MODE   = 4'd8,
    EV_OLD_OK       = 4'd9,
    EV_CHANGED      = 4'd10,
    EV_OLD_WRONG    = 4'd11
  } event_e;

  // request kinds on the input channel
  typedef enum logic [1:0] {
    CMD_KEY       = 2'd0,
    CMD_LONG_STAR = 2'd1,
    CMD_TICK      = 2'd2,
    CMD_UNUSED    = 2'd3
  } cmd_e;

  // key codes
  localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
  localparam logic [3:0] KEY_STAR      = 4'd10;
  localparam logic [3:0] KEY_HASH      = 4'd11;

  // configuration register indexes (byte address is 4 * index)
  typedef enum logic [1:0] {
    REG_MAX_WRONG     = 2'd0,
    REG_LOCKOUT_TICKS = 2'd1,
    REG_OPEN_TICKS    = 2'd2,
    REG_NONE          = 2'd3
  } reg_e;

  localparam int          CFG_ADDR_W         = 4;
  localparam logic [2:0]  MAX_WRONG_RST      = 3'd3;
  localparam logic [3:0]  LOCKOUT_TICKS_RST  = 4'd10;
  localparam logic [3:0]  OPEN_TICKS_RST     = 4'd10;

  // factory code 1382, remaining stored digits reset to zero
  localparam int          RST_CODE_LEN = 4;
  localparam logic [3:0]  RST_CODE [RST_CODE_LEN] = '{4'd1, 4'd3, 4'd8, 4'd2};

endpackage

@@ sv/keypad_code_lock_controller.sv @@
// keypad code lock controller top level
//
// Takes decoded keypad requests (digit, star submit, hash erase or lock), long
// star presses and timer ticks, and answers every request with exactly one
// result: an event code plus a snapshot of the lock state (door, mode, digits
// entered, ticks left, wrong tries). A request is held in an input register
// and processed once the result register is free, by one pass of logic that
// updates the state and loads the result register, so one request per cycle
// is sustained while out_stall_i is low; a request passes through the input
// register and then the result register. The result register holds a result
// while out_stall_i is high; one more request waits in the input register
// meanwhile. The code check compares the entered digits against the stored
// code in parallel. The stored code resets to 1382. Registers on the
// APB-style port (byte addresses): 0x0 max_wrong, 0x4 lockout_ticks, 0x8
// open_ticks; write them only while no request is in flight.
module keypad_code_lock_controller #(
  parameter int MAX_DIGITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // request channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [1:0]                           cmd_i,
  input  logic [3:0]                           key_code_i,
  // result channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [3:0]                           event_res_o,
  output logic                                 door_open_o,
  output logic [2:0]                           mode_o,
  output logic [$clog2(MAX_DIGITS+1)-1:0]      entry_length_o,
  output logic [3:0]                           countdown_o,
  output logic [2:0]                           wrong_count_o,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [klc_pkg::CFG_ADDR_W-1:0]       paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W = $clog2(MAX_DIGITS);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DIGITS);

  // configuration registers
  logic [2:0] max_wrong_q;
  logic [3:0] lockout_ticks_q;
  logic [3:0] open_ticks_q;
  klc_pkg::reg_e cfg_idx;
  logic       cfg_wr;

  // input register
  logic       s1_valid_q;
  logic [1:0] cmd_q;
  logic [3:0] key_q;
  logic       in_accept;

  // result register
  logic              out_valid_q;
  klc_pkg::event_e   event_q, event_d;
  logic              adv;    // result register free or being taken
  logic              fire;   // request processed this cycle

  // lock state
  klc_pkg::mode_e    mode_q, mode_d;
  logic [3:0]        stored_q [MAX_DIGITS];
  logic [3:0]        stored_d [MAX_DIGITS];
  logic [CNT_W-1:0]  stored_len_q, stored_len_d;
  logic [3:0]        entry_q [MAX_DIGITS];
  logic [3:0]        entry_d [MAX_DIGITS];
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [2:0]        wrong_q, wrong_d;
  logic [3:0]        ticks_q, ticks_d;

  // entry with the incoming digit written, and what a submit compares
  logic [3:0]        ent_wr  [MAX_DIGITS];
  logic [3:0]        sub_arr [MAX_DIGITS];
  logic [CNT_W-1:0]  cnt_inc;
  logic [CNT_W-1:0]  sub_cnt;
  logic              is_digit;
  logic              match;
  logic              do_sub;
  logic [2:0]        wrong_inc;

  // ---------------------------------------------------------------------------
  // configuration port: zero wait states, reads return the register value
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_idx = klc_pkg::reg_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_wrong_q     <= klc_pkg::MAX_WRONG_RST;
      lockout_ticks_q <= klc_pkg::LOCKOUT_TICKS_RST;
      open_ticks_q    <= klc_pkg::OPEN_TICKS_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        klc_pkg::REG_MAX_WRONG:     max_wrong_q     <= pwdata[2:0];
        klc_pkg::REG_LOCKOUT_TICKS: lockout_ticks_q <= pwdata[3:0];
        klc_pkg::REG_OPEN_TICKS:    open_ticks_q    <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      klc_pkg::REG_MAX_WRONG:     prdata = {29'd0, max_wrong_q};
      klc_pkg::REG_LOCKOUT_TICKS: prdata = {28'd0, lockout_ticks_q};
      klc_pkg::REG_OPEN_TICKS:    prdata = {28'd0, open_ticks_q};
      default:                    prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // handshake: while out_stall_i is low, the input register feeds the result register one request per cycle
  // ---------------------------------------------------------------------------
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !adv;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign fire       = s1_valid_q && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) s1_valid_q <= in_valid_i;
      if (adv)         out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q <= cmd_i;
      key_q <= key_code_i;
    end
    if (fire) event_q <= event_d;
  end

  // ---------------------------------------------------------------------------
  // entry buffer write and code compare
  // ---------------------------------------------------------------------------
  assign cnt_inc  = cnt_q + CNT_W'(1);
  assign is_digit = (klc_pkg::cmd_e'(cmd_q) == klc_pkg::CMD_KEY) &&
                    (key_q <= klc_pkg::KEY_DIGIT_MAX);

  always_comb begin
    for (int k = 0; k < MAX_DIGITS; k++) begin
      if ((cnt_q < CNT_MAX) && (cnt_q[IDX_W-1:0] == IDX_W'(k))) ent_wr[k] = key_q;
      else                                                      ent_wr[k] = entry_q[k];
    end
  end

  // a digit that fills the buffer submits the buffer including itself
  always_comb begin
    for (int k = 0; k < MAX_DIGITS; k++) begin
      sub_arr[k] = is_digit ? ent_wr[k] : entry_q[k];
    end
    sub_cnt = is_digit ? cnt_inc : cnt_q;
  end

  always_comb begin
    match = (sub_cnt == stored_len_q);
    for (int k = 0; k < MAX_DIGITS; k++) begin
      if ((CNT_W'(k) < sub_cnt) && (sub_arr[k] != stored_q[k])) match = 1'b0;
    end
  end

  assign wrong_inc = wrong_q + 3'd1;

  // ---------------------------------------------------------------------------
  // state update for one request
  // ---------------------------------------------------------------------------
  always_comb begin
    mode_d       = mode_q;
    stored_d     = stored_q;
    stored_len_d = stored_len_q;
    entry_d      = entry_q;
    cnt_d        = cnt_q;
    wrong_d      = wrong_q;
    ticks_d      = ticks_q;
    event_d      = klc_pkg::EV_NONE;
    do_sub       = 1'b0;

    case (klc_pkg::cmd_e'(cmd_q))
      klc_pkg::CMD_KEY: begin
        if (mode_q == klc_pkg::MODE_OPEN) begin
          // only hash acts while open: lock the door
          if (key_q == klc_pkg::KEY_HASH) begin
            mode_d  = klc_pkg::MODE_ENTRY;
            ticks_d = 4'd0;
            cnt_d   = '0;
            event_d = klc_pkg::EV_LOCKED;
          end
        end else if (mode_q != klc_pkg::MODE_LOCKOUT) begin
          if (key_q <= klc_pkg::KEY_DIGIT_MAX) begin
            entry_d = ent_wr;
            cnt_d   = cnt_inc;
            if (cnt_inc >= CNT_MAX) do_sub = 1'b1;
            else                    event_d = klc_pkg::EV_DIGIT;
          end else if (key_q == klc_pkg::KEY_STAR) begin
            do_sub = 1'b1;
          end else if (key_q == klc_pkg::KEY_HASH) begin
            // backspace, ignored on an empty entry
            if (cnt_q != '0) begin
              cnt_d   = cnt_q - CNT_W'(1);
              event_d = klc_pkg::EV_ERASED;
            end
          end
        end
      end
      klc_pkg::CMD_LONG_STAR: begin
        if ((mode_q == klc_pkg::MODE_ENTRY) && (cnt_q == '0)) begin
          mode_d  = klc_pkg::MODE_OLD;
          wrong_d = 3'd0;
          event_d = klc_pkg::EV_RESET_MODE;
        end else if ((mode_q == klc_pkg::MODE_ENTRY) || (mode_q == klc_pkg::MODE_OLD) ||
                     (mode_q == klc_pkg::MODE_NEW)) begin
          do_sub = 1'b1;
        end
      end
      klc_pkg::CMD_TICK: begin
        if ((mode_q == klc_pkg::MODE_OPEN) || (mode_q == klc_pkg::MODE_LOCKOUT)) begin
          if (ticks_q <= 4'd1) begin
            event_d = (mode_q == klc_pkg::MODE_OPEN) ? klc_pkg::EV_LOCKED
                                                     : klc_pkg::EV_LOCKOUT_OVER;
            ticks_d = 4'd0;
            mode_d  = klc_pkg::MODE_ENTRY;
            cnt_d   = '0;
          end else begin
            ticks_d = ticks_q - 4'd1;
          end
        end
      end
      default: ;
    endcase

    // submit of the entry; every submit empties the buffer
    if (do_sub) begin
      cnt_d = '0;
      case (mode_q)
        klc_pkg::MODE_ENTRY: begin
          if (match) begin
            wrong_d = 3'd0;
            mode_d  = klc_pkg::MODE_OPEN;
            ticks_d = open_ticks_q;
            event_d = klc_pkg::EV_OPENED;
          end else if (wrong_inc >= max_wrong_q) begin
            wrong_d = 3'd0;
            mode_d  = klc_pkg::MODE_LOCKOUT;
            ticks_d = lockout_ticks_q;
            event_d = klc_pkg::EV_LOCKOUT;
          end else begin
            wrong_d = wrong_inc;
            event_d = klc_pkg::EV_WRONG;
          end
        end
        klc_pkg::MODE_OLD: begin
          mode_d  = match ? klc_pkg::MODE_NEW : klc_pkg::MODE_ENTRY;
          event_d = match ? klc_pkg::EV_OLD_OK : klc_pkg::EV_OLD_WRONG;
        end
        klc_pkg::MODE_NEW: begin
          // take the entry as the new code, unused digits cleared
          for (int k = 0; k < MAX_DIGITS; k++) begin
            stored_d[k] = (CNT_W'(k) < sub_cnt) ? sub_arr[k] : 4'd0;
          end
          stored_len_d = sub_cnt;
          mode_d       = klc_pkg::MODE_ENTRY;
          event_d      = klc_pkg::EV_CHANGED;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= klc_pkg::MODE_ENTRY;
      stored_len_q <= CNT_W'(klc_pkg::RST_CODE_LEN);
      cnt_q        <= '0;
      wrong_q      <= 3'd0;
      ticks_q      <= 4'd0;
      for (int k = 0; k < MAX_DIGITS; k++) begin
        stored_q[k] <= (k < klc_pkg::RST_CODE_LEN) ?
                       klc_pkg::RST_CODE[k % klc_pkg::RST_CODE_LEN] : 4'd0;
      end
    end else if (fire) begin
      mode_q       <= mode_d;
      stored_q     <= stored_d;
      stored_len_q <= stored_len_d;
      cnt_q        <= cnt_d;
      wrong_q      <= wrong_d;
      ticks_q      <= ticks_d;
    end
  end

  // entry digits are not reset, only ever read below the fill count
  always_ff @(posedge clk_i) begin
    if (fire) entry_q <= entry_d;
  end

  // result fields: event register plus state snapshot, held while stalled
  assign out_valid_o    = out_valid_q;
  assign event_res_o    = event_q;
  assign door_open_o    = (mode_q == klc_pkg::MODE_OPEN);
  assign mode_o         = mode_q;
  assign entry_length_o = cnt_q;
  assign countdown_o    = ticks_q;
  assign wrong_count_o  = wrong_q;

endmodule

@@ sv/klc_checker.sv @@
// port level checks of the keypad code lock controller and their bind
module klc_sva (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [3:0] event_res_o,
  input logic       door_open_o,
  input logic [2:0] mode_o,
  input logic [3:0] countdown_o,
  input logic [2:0] wrong_count_o
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(event_res_o))
    else $error("result changed while stalled");

  // a successful code opens the door and clears the wrong tries
  a_opened: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_res_o == klc_pkg::EV_OPENED) |->
      door_open_o && (mode_o == klc_pkg::MODE_OPEN) && (wrong_count_o == 3'd0))
    else $error("opened event without open door");

  // a lockout clears the wrong tries
  a_lockout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_res_o == klc_pkg::EV_LOCKOUT) |->
      (mode_o == klc_pkg::MODE_LOCKOUT) && (wrong_count_o == 3'd0) && !door_open_o)
    else $error("lockout event with wrong state");

  // countdown only runs in open or lockout mode
  a_countdown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (mode_o != klc_pkg::MODE_OPEN) && (mode_o != klc_pkg::MODE_LOCKOUT) |->
      (countdown_o == 4'd0))
    else $error("countdown running outside open or lockout");

endmodule

bind keypad_code_lock_controller klc_sva u_klc_sva (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .event_res_o   (event_res_o),
  .door_open_o   (door_open_o),
  .mode_o        (mode_o),
  .countdown_o   (countdown_o),
  .wrong_count_o (wrong_count_o)
);
